// File: src/mhd_pkg.sv
// shared types and constants for the ml-dsa hint decoder
`timescale 1ns / 1ps

package mhd_pkg;

    localparam int BYTE_W          = 8;
    localparam int POLY_CNT_W      = 4;
    localparam int POLY_IDX_W      = 3;
    localparam int POS_W           = 9;
    localparam int HINT_WORD_W     = 64;
    localparam int COEFFS_PER_POLY = 256;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // register index, taken from paddr[2]
    localparam logic REG_HINT_LIMIT = 1'b0;
    localparam logic REG_POLY_COUNT = 1'b1;

    localparam logic [BYTE_W-1:0]     HINT_LIMIT_RST = 8'd80;
    localparam logic [POLY_CNT_W-1:0] POLY_COUNT_RST = 4'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] sig_byte;
        logic              section_start;
    } sig_word_t;

    typedef struct packed {
        logic [POLY_IDX_W-1:0]  poly_index;
        logic [HINT_WORD_W-1:0] hint_bits_0;
        logic [HINT_WORD_W-1:0] hint_bits_1;
        logic [HINT_WORD_W-1:0] hint_bits_2;
        logic [HINT_WORD_W-1:0] hint_bits_3;
        logic                   bad;
        logic                   last;
    } hint_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } mhd_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic finish;
    } mhd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_limit;
        logic skip_walk;
        logic walk_last;
        logic out_free;
    } mhd_stat_t;

endpackage

// File: src/mhd_ctrl.sv
// controller state machine for the hint decoder
`timescale 1ns / 1ps

module mhd_ctrl
    import mhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sig_valid,
    output logic      sig_ready,
    input  mhd_stat_t stat,
    output mhd_cmd_t  cmd
);

    mhd_state_t state_reg;
    mhd_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sig_valid && stat.is_limit)
                begin
                    state_next = stat.skip_walk ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        sig_ready     = 1'b0;
        cmd.accept    = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sig_ready  = 1'b1;
                cmd.accept = sig_valid;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                sig_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/mhd_datapath.sv
// index buffer, walk counter, checks and bitmap for the hint decoder
`timescale 1ns / 1ps

module mhd_datapath
    import mhd_pkg::*;
#(
    parameter int MAX_HINTS = 128,
    parameter int MAX_POLYS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BYTE_W-1:0]     hint_limit,
    input  logic [POLY_CNT_W-1:0] poly_count,
    input  sig_word_t             sig_word,
    input  mhd_cmd_t              cmd,
    output mhd_stat_t             stat,
    output logic                  hint_valid,
    input  logic                  hint_ready,
    output hint_word_t            hint_word
);

    localparam int IW = (MAX_HINTS > 1) ? $clog2(MAX_HINTS) : 1;
    localparam logic [BYTE_W-1:0]     MAX_HINTS_B = BYTE_W'(MAX_HINTS);
    localparam logic [POLY_CNT_W-1:0] MAX_POLYS_B = POLY_CNT_W'(MAX_POLYS);

    // index buffer
    logic [BYTE_W-1:0] mem [0:MAX_HINTS-1];
    logic [BYTE_W-1:0] rd_data_reg;

    // section state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] cons_reg, cons_next;
    logic              err_reg, err_next;

    // per-polynomial walk state
    logic [BYTE_W-1:0]          cnt_reg, cnt_next;
    logic [BYTE_W-1:0]          lim_reg, lim_next;
    logic [BYTE_W-1:0]          end_reg, end_next;
    logic [BYTE_W-1:0]          prev_reg, prev_next;
    logic [POLY_IDX_W-1:0]      poly_reg, poly_next;
    logic                       last_reg, last_next;
    logic                       fail_reg, fail_next;
    logic                       first_reg, first_next;
    logic [COEFFS_PER_POLY-1:0] bits_reg, bits_next;

    // read pipeline flags
    logic rd_valid_reg, rd_valid_next;
    logic rd_pad_reg, rd_pad_next;
    logic rd_first_reg, rd_first_next;

    // result register
    logic       hint_valid_reg, hint_valid_next;
    hint_word_t hint_word_reg, hint_word_next;

    // decode of the offered byte
    logic [BYTE_W-1:0]     omega;
    logic [POLY_CNT_W-1:0] polys;
    logic [POS_W-1:0]      pos_eff, span, poly_full;
    logic [BYTE_W-1:0]     cons_eff, lim_in, walk_end;
    logic                  err_eff, is_index, is_limit, last_in, range_fail;
    logic                  bad_out;

    always_comb
    begin
        omega = (hint_limit > MAX_HINTS_B) ? MAX_HINTS_B : hint_limit;
        if (poly_count == '0)
        begin
            polys = POLY_CNT_W'(1);
        end
        else if (poly_count > MAX_POLYS_B)
        begin
            polys = MAX_POLYS_B;
        end
        else
        begin
            polys = poly_count;
        end
        pos_eff    = sig_word.section_start ? '0 : pos_reg;
        cons_eff   = sig_word.section_start ? '0 : cons_reg;
        err_eff    = sig_word.section_start ? 1'b0 : err_reg;
        span       = POS_W'(omega) + POS_W'(polys);
        is_index   = pos_eff < POS_W'(omega);
        is_limit   = (pos_eff < span) && !is_index;
        poly_full  = pos_eff - POS_W'(omega);
        last_in    = (poly_full[POLY_CNT_W-1:0] + POLY_CNT_W'(1)) == polys;
        lim_in     = sig_word.sig_byte;
        range_fail = (lim_in < cons_eff) || (lim_in > omega);
        walk_end   = last_in ? omega : lim_in;
    end

    // status to the controller
    assign stat.is_limit  = is_limit;
    assign stat.skip_walk = range_fail || err_eff || (cons_eff == walk_end);
    assign stat.walk_last = (cnt_reg + BYTE_W'(1)) == end_reg;
    assign stat.out_free  = !hint_valid_reg || hint_ready;

    assign bad_out = err_reg || fail_reg;

    // next values
    always_comb
    begin
        pos_next        = pos_reg;
        cons_next       = cons_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        lim_next        = lim_reg;
        end_next        = end_reg;
        prev_next       = prev_reg;
        poly_next       = poly_reg;
        last_next       = last_reg;
        fail_next       = fail_reg;
        first_next      = first_reg;
        bits_next       = bits_reg;
        rd_valid_next   = 1'b0;
        rd_pad_next     = rd_pad_reg;
        rd_first_next   = rd_first_reg;
        hint_valid_next = hint_valid_reg;
        hint_word_next  = hint_word_reg;

        // byte taken: clear on section start, then store or open a polynomial
        if (cmd.accept)
        begin
            pos_next  = pos_eff;
            cons_next = cons_eff;
            err_next  = err_eff;
            if (is_index || is_limit)
            begin
                pos_next = pos_eff + POS_W'(1);
            end
            if (is_limit)
            begin
                poly_next  = poly_full[POLY_IDX_W-1:0];
                last_next  = last_in;
                lim_next   = lim_in;
                end_next   = walk_end;
                cnt_next   = cons_eff;
                fail_next  = range_fail;
                first_next = 1'b1;
                bits_next  = '0;
            end
        end

        // issue one buffer read per cycle
        if (cmd.walk_step)
        begin
            cnt_next      = cnt_reg + BYTE_W'(1);
            first_next    = 1'b0;
            rd_valid_next = 1'b1;
            rd_pad_next   = cnt_reg >= lim_reg;
            rd_first_next = first_reg;
        end

        // check returned index: rising order, or zero in the padding
        if (rd_valid_reg)
        begin
            if (rd_pad_reg)
            begin
                if (rd_data_reg != '0)
                begin
                    fail_next = 1'b1;
                end
            end
            else
            begin
                if (!rd_first_reg && (rd_data_reg <= prev_reg))
                begin
                    fail_next = 1'b1;
                end
                bits_next[rd_data_reg] = 1'b1;
                prev_next = rd_data_reg;
            end
        end

        // result handshake
        if (hint_valid_reg && hint_ready)
        begin
            hint_valid_next = 1'b0;
        end

        // load the result and close the polynomial
        if (cmd.finish)
        begin
            hint_valid_next           = 1'b1;
            hint_word_next.poly_index = poly_reg;
            hint_word_next.last       = last_reg;
            hint_word_next.bad        = bad_out;
            hint_word_next.hint_bits_0 = bad_out ? '0 : bits_reg[HINT_WORD_W-1:0];
            hint_word_next.hint_bits_1 = bad_out ? '0 : bits_reg[2*HINT_WORD_W-1:HINT_WORD_W];
            hint_word_next.hint_bits_2 = bad_out ? '0
                                                 : bits_reg[3*HINT_WORD_W-1:2*HINT_WORD_W];
            hint_word_next.hint_bits_3 = bad_out ? '0
                                                 : bits_reg[4*HINT_WORD_W-1:3*HINT_WORD_W];
            err_next = bad_out;
            if (!fail_reg)
            begin
                cons_next = lim_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            cons_reg       <= '0;
            err_reg        <= 1'b0;
            rd_valid_reg   <= 1'b0;
            hint_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            cons_reg       <= cons_next;
            err_reg        <= err_next;
            rd_valid_reg   <= rd_valid_next;
            hint_valid_reg <= hint_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        lim_reg       <= lim_next;
        end_reg       <= end_next;
        prev_reg      <= prev_next;
        poly_reg      <= poly_next;
        last_reg      <= last_next;
        fail_reg      <= fail_next;
        first_reg     <= first_next;
        bits_reg      <= bits_next;
        rd_pad_reg    <= rd_pad_next;
        rd_first_reg  <= rd_first_next;
        hint_word_reg <= hint_word_next;
    end

    // index buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_index)
        begin
            mem[pos_eff[IW-1:0]] <= sig_word.sig_byte;
        end
        if (cmd.walk_step)
        begin
            rd_data_reg <= mem[cnt_reg[IW-1:0]];
        end
    end

    assign hint_valid = hint_valid_reg;
    assign hint_word  = hint_word_reg;

    // walk stays inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (32'(cnt_reg) < MAX_HINTS))
        else $error("walk address beyond index buffer");

    // read data is checked in the cycle after its read was issued
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.walk_step))
        else $error("index checked without a read");

    // a malformed result carries an empty bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        (hint_valid_reg && hint_word_reg.bad) |->
        (hint_word_reg.hint_bits_0 == '0 && hint_word_reg.hint_bits_1 == '0 &&
         hint_word_reg.hint_bits_2 == '0 && hint_word_reg.hint_bits_3 == '0))
        else $error("bad result with nonzero bitmap");

endmodule

// File: src/mldsa_hint_decoder.sv
// top level of the ml-dsa hint decoder: register port, controller, datapath
`timescale 1ns / 1ps

// ML-DSA hint section decoder. Feed the hint section one byte per word on the
// sig channel, section_start set on its first byte: first hint_limit index
// bytes, then poly_count cumulative limit bytes. Each limit byte gives one
// word on the hint channel with that polynomial's 256-bit hint bitmap in four
// 64-bit lanes; bad latches for the rest of the section once the encoding is
// malformed, and last marks the final polynomial, whose padding bytes are
// checked for zero. An index byte is written to the index buffer as it is
// taken. A limit byte walks its stored indices through the single-port index
// buffer at one read per cycle, reading n entries (limit minus the previous
// limit, or the hint limit capped at MAX_HINTS minus the previous limit on the
// last polynomial); nothing is read when n is zero, the limit is out of range
// or the section is already bad. Bytes past the section give no word. A result
// waiting on the hint channel does not stop index bytes from being taken. The
// index buffer has no reset.
module mldsa_hint_decoder
    import mhd_pkg::*;
#(
    parameter int MAX_HINTS = 128,
    parameter int MAX_POLYS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  sig_valid,
    output logic                  sig_ready,
    input  sig_word_t             sig_word,
    output logic                  hint_valid,
    input  logic                  hint_ready,
    output hint_word_t            hint_word
);

    logic [BYTE_W-1:0]     hint_limit_reg;
    logic [POLY_CNT_W-1:0] poly_count_reg;
    logic                  cfg_write;
    mhd_cmd_t              cmd;
    mhd_stat_t             stat;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_limit_reg <= HINT_LIMIT_RST;
            poly_count_reg <= POLY_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HINT_LIMIT:
                begin
                    hint_limit_reg <= pwdata[BYTE_W-1:0];
                end
                REG_POLY_COUNT:
                begin
                    poly_count_reg <= pwdata[POLY_CNT_W-1:0];
                end
                default:
                begin
                    hint_limit_reg <= hint_limit_reg;
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_HINT_LIMIT: prdata = APB_DATA_W'(hint_limit_reg);
            REG_POLY_COUNT: prdata = APB_DATA_W'(poly_count_reg);
            default:        prdata = '0;
        endcase
    end

    // controller
    mhd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sig_valid (sig_valid),
        .sig_ready (sig_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    mhd_datapath #(
        .MAX_HINTS (MAX_HINTS),
        .MAX_POLYS (MAX_POLYS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .hint_limit (hint_limit_reg),
        .poly_count (poly_count_reg),
        .sig_word   (sig_word),
        .cmd        (cmd),
        .stat       (stat),
        .hint_valid (hint_valid),
        .hint_ready (hint_ready),
        .hint_word  (hint_word)
    );

endmodule
